@@ design/srft_pkg.sv @@
// Shared types and constants for the stove remote frame transmitter.
// Holds the configuration bundle, result bundle, phase encoding and data word builders.
// No dependencies.
package srft_pkg;

	localparam int WORD_BITS   = 12;
	localparam int FRAME_WORDS = 7;
	localparam int ID_BITS     = 3 * WORD_BITS;
	localparam int DUR_BITS    = 16;
	localparam int RPT_BITS    = 8;
	localparam int CFG_DATA_W  = ID_BITS;
	localparam int CFG_IDX_W   = 3;
	localparam int BIT_IDX_W   = $clog2(WORD_BITS);
	localparam int WORD_IDX_W  = $clog2(FRAME_WORDS + 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TX_ID     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_ONE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_TWO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MSG_GAP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd6;

	// register reset values
	localparam logic [ID_BITS-1:0]   RST_TX_ID     = 36'h97D999813;
	localparam logic [WORD_BITS-1:0] RST_CHECK_ONE = 12'hCA9;
	localparam logic [WORD_BITS-1:0] RST_CHECK_TWO = 12'hAEB;
	localparam logic [DUR_BITS-1:0]  RST_HALF_BIT  = 16'd390;
	localparam logic [DUR_BITS-1:0]  RST_WORD_GAP  = 16'd860;
	localparam logic [DUR_BITS-1:0]  RST_MSG_GAP   = 16'd5080;
	localparam logic [RPT_BITS-1:0]  RST_REPEAT    = 8'd5;

	// position of each word within a frame
	localparam logic [WORD_IDX_W-1:0] WPOS_ID_ONE    = 3'd0;
	localparam logic [WORD_IDX_W-1:0] WPOS_ID_TWO    = 3'd1;
	localparam logic [WORD_IDX_W-1:0] WPOS_ID_THREE  = 3'd2;
	localparam logic [WORD_IDX_W-1:0] WPOS_DATA_ONE  = 3'd3;
	localparam logic [WORD_IDX_W-1:0] WPOS_CHECK_ONE = 3'd4;
	localparam logic [WORD_IDX_W-1:0] WPOS_DATA_TWO  = 3'd5;
	localparam logic [WORD_IDX_W-1:0] WPOS_CHECK_TWO = 3'd6;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SEND = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_WGAP = 4'b0010,
		PH_BITS = 4'b0100,
		PH_MGAP = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   tx_id;
		logic [WORD_BITS-1:0] check_one;
		logic [WORD_BITS-1:0] check_two;
		logic [DUR_BITS-1:0]  half_bit;
		logic [DUR_BITS-1:0]  word_gap;
		logic [DUR_BITS-1:0]  msg_gap;
		logic [RPT_BITS-1:0]  repeat_cnt;
	} cfg_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic sequence_done;
	} res_t;

	// ten leading bits, then a parity bit set on an even ones count, then a closing one
	function automatic logic [WORD_BITS-1:0] close_word(input logic [9:0] lead);
		close_word = {lead, ~^lead, 1'b1};
	endfunction

	function automatic logic [WORD_BITS-1:0] data_word_one(
		input logic [2:0] cmd, input logic [2:0] pw, input logic [2:0] fan);
		data_word_one = close_word({1'b1, fan, pw, cmd});
	endfunction

	function automatic logic [WORD_BITS-1:0] data_word_two(
		input logic [2:0] cmd, input logic [2:0] pw, input logic [2:0] fan);
		logic [9:0] lead;
		lead = {1'b1,
			fan[2] ^ fan[1] ^ pw[0],
			~(fan[1] ^ fan[0]),
			~((~fan[0]) ^ pw[2] ^ cmd[1]),
			~pw[2],
			fan[2] ^ pw[1],
			fan[1] ^ pw[0],
			~fan[0],
			~(pw[2] ^ cmd[1]),
			1'b0};
		data_word_two = close_word(lead);
	endfunction

endpackage

@@ design/srft_cfg_regs.sv @@
// Configuration register file of the stove remote frame transmitter.
// Depends on srft_pkg for register indexes, reset values and the cfg_t bundle.
module srft_cfg_regs
	import srft_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tx_id      <= RST_TX_ID;
			cfg_q.check_one  <= RST_CHECK_ONE;
			cfg_q.check_two  <= RST_CHECK_TWO;
			cfg_q.half_bit   <= RST_HALF_BIT;
			cfg_q.word_gap   <= RST_WORD_GAP;
			cfg_q.msg_gap    <= RST_MSG_GAP;
			cfg_q.repeat_cnt <= RST_REPEAT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TX_ID:     cfg_q.tx_id      <= cfg_data;
				REG_CHECK_ONE: cfg_q.check_one  <= cfg_data[WORD_BITS-1:0];
				REG_CHECK_TWO: cfg_q.check_two  <= cfg_data[WORD_BITS-1:0];
				REG_HALF_BIT:  cfg_q.half_bit   <= cfg_data[DUR_BITS-1:0];
				REG_WORD_GAP:  cfg_q.word_gap   <= cfg_data[DUR_BITS-1:0];
				REG_MSG_GAP:   cfg_q.msg_gap    <= cfg_data[DUR_BITS-1:0];
				REG_REPEAT:    cfg_q.repeat_cnt <= cfg_data[RPT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/srft_sequencer.sv @@
// Frame sequencer: phase, word, bit and tick counters, and the line level of each item.
// Depends on srft_pkg for phase encoding, word builders and the cfg_t / res_t bundles.
module srft_sequencer
	import srft_pkg::*;
#(
	parameter int TIMER_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       opcode,
	input  logic [2:0] command,
	input  logic [2:0] power_level,
	input  logic [2:0] fan_level,
	input  cfg_t       cfg,
	output res_t       res
);

	phase_t                  phase_q, phase_nx;
	logic [RPT_BITS-1:0]     rep_q, rep_nx;
	logic [WORD_IDX_W-1:0]   word_q, word_nx, word_inc;
	logic [BIT_IDX_W-1:0]    bit_q, bit_nx, bit_inc, bit_sel;
	logic                    half_q, half_nx;
	logic [TIMER_WIDTH-1:0]  cnt_q, cnt_nx, cnt_inc, limit, lim_raw;
	logic [WORD_BITS-1:0]    dw1_q, dw2_q, cur_word;
	logic [BIT_IDX_W-1:0]    bit_pos;
	logic                    cur_lvl, load;

	always_comb begin
		case (word_q)
			WPOS_ID_ONE:    cur_word = cfg.tx_id[ID_BITS-1 -: WORD_BITS];
			WPOS_ID_TWO:    cur_word = cfg.tx_id[2*WORD_BITS-1 -: WORD_BITS];
			WPOS_ID_THREE:  cur_word = cfg.tx_id[WORD_BITS-1:0];
			WPOS_DATA_ONE:  cur_word = dw1_q;
			WPOS_CHECK_ONE: cur_word = cfg.check_one;
			WPOS_DATA_TWO:  cur_word = dw2_q;
			WPOS_CHECK_TWO: cur_word = cfg.check_two;
			default:        cur_word = '0;
		endcase
	end

	// clamp the bit index and pick MSB first
	assign bit_sel = (bit_q < BIT_IDX_W'(WORD_BITS)) ? bit_q : BIT_IDX_W'(WORD_BITS - 1);
	assign bit_pos = BIT_IDX_W'(WORD_BITS - 1) - bit_sel;

	always_comb begin
		case (phase_q)
			PH_WGAP: cur_lvl = 1'b1;
			PH_BITS: cur_lvl = cur_word[bit_pos] ^ half_q;
			default: cur_lvl = 1'b0;
		endcase
	end

	always_comb begin
		case (phase_q)
			PH_WGAP: lim_raw = TIMER_WIDTH'(cfg.word_gap);
			PH_BITS: lim_raw = TIMER_WIDTH'(cfg.half_bit);
			default: lim_raw = TIMER_WIDTH'(cfg.msg_gap);
		endcase
		limit = (lim_raw == '0) ? TIMER_WIDTH'(1) : lim_raw;
	end

	assign cnt_inc  = cnt_q + TIMER_WIDTH'(1);
	assign bit_inc  = bit_q + BIT_IDX_W'(1);
	assign word_inc = word_q + WORD_IDX_W'(1);

	always_comb begin
		phase_nx = phase_q;
		rep_nx   = rep_q;
		word_nx  = word_q;
		bit_nx   = bit_q;
		half_nx  = half_q;
		cnt_nx   = cnt_q;
		load     = 1'b0;
		res      = '0;
		if (opcode == OP_SEND) begin
			res.busy_res = 1'b1;
			if (phase_q == PH_IDLE) begin
				load     = 1'b1;
				rep_nx   = (cfg.repeat_cnt == '0) ? RPT_BITS'(1) : cfg.repeat_cnt;
				word_nx  = '0;
				bit_nx   = '0;
				half_nx  = 1'b0;
				cnt_nx   = '0;
				phase_nx = PH_WGAP;
				// the word gap comes first
				res.line_level = 1'b1;
			end else begin
				res.line_level = cur_lvl;
			end
		end else if (phase_q != PH_IDLE) begin
			res.busy_res   = 1'b1;
			res.line_level = cur_lvl;
			if (cnt_inc >= limit || cnt_inc == '0) begin
				cnt_nx = '0;
				case (phase_q)
					PH_WGAP: begin
						phase_nx = PH_BITS;
						bit_nx   = '0;
						half_nx  = 1'b0;
					end
					PH_BITS: begin
						if (!half_q) begin
							half_nx = 1'b1;
						end else begin
							half_nx = 1'b0;
							bit_nx  = bit_inc;
							if (bit_inc >= BIT_IDX_W'(WORD_BITS)) begin
								bit_nx   = '0;
								word_nx  = word_inc;
								phase_nx = (word_inc >= WORD_IDX_W'(FRAME_WORDS)) ?
									PH_MGAP : PH_WGAP;
							end
						end
					end
					default: begin
						rep_nx  = rep_q - RPT_BITS'(1);
						word_nx = '0;
						if (rep_q == RPT_BITS'(1)) begin
							phase_nx          = PH_IDLE;
							res.sequence_done = 1'b1;
						end else begin
							phase_nx = PH_WGAP;
						end
					end
				endcase
			end else begin
				cnt_nx = cnt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rep_q   <= '0;
			word_q  <= '0;
			bit_q   <= '0;
			half_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_nx;
			rep_q   <= rep_nx;
			word_q  <= word_nx;
			bit_q   <= bit_nx;
			half_q  <= half_nx;
			cnt_q   <= cnt_nx;
		end
	end

	// latch the data words on a request taken while idle
	always_ff @(posedge clk) begin
		if (accept && load) begin
			dw1_q <= data_word_one(command, power_level, fan_level);
			dw2_q <= data_word_two(command, power_level, fan_level);
		end
	end

endmodule

@@ design/srft_out_buf.sv @@
// Two-entry result buffer between the sequencer and the output channel.
// Depends on srft_pkg for the res_t bundle.
module srft_out_buf
	import srft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic can_push,
	output logic out_valid,
	input  logic out_ready,
	output res_t head
);

	res_t        d0_q, d1_q;
	logic [1:0]  cnt_q;
	logic        pop;

	assign can_push  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign head      = d0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					d0_q <= push_data;
				end else begin
					d1_q <= push_data;
				end
			end
			2'b01: d0_q <= d1_q;
			// push with pop only happens with one entry held
			2'b11: d0_q <= push_data;
			default: ;
		endcase
	end

endmodule

@@ design/stove_remote_frame_transmitter_top.sv @@
// Top level of the stove remote frame transmitter.
// Instantiates srft_cfg_regs, srft_sequencer and srft_out_buf; uses srft_pkg.
//
// Each input item is either a one-microsecond tick or a send request, and each
// gives exactly one result: the line level for that tick, a busy flag and a done
// flag on the tick that ends the last repeat. One item is taken every clock while
// the two-entry buffer has room: the sequencer state advances on each transfer and
// its result goes into the buffer, so input stays open while one result waits.
// Requests while a sequence runs are ignored. Register writes take effect at once.
module stove_remote_frame_transmitter_top
	import srft_pkg::*;
#(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [2:0]            command,
	input  logic [2:0]            power_level,
	input  logic [2:0]            fan_level,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  line_level,
	output logic                  busy_res,
	output logic                  sequence_done
);

	cfg_t cfg;
	res_t res, head;
	logic accept;

	assign accept = in_valid && in_ready;

	srft_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	srft_sequencer #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.opcode      (opcode),
		.command     (command),
		.power_level (power_level),
		.fan_level   (fan_level),
		.cfg         (cfg),
		.res         (res)
	);

	srft_out_buf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign line_level    = head.line_level;
	assign busy_res      = head.busy_res;
	assign sequence_done = head.sequence_done;

endmodule
